/* src/gpg_pkg.sv */
// gpg_pkg: shared widths, codes, types and helper functions of the
// performance-state governor. No dependencies; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package gpg_pkg;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned TEMP_W     = 18;
  localparam int unsigned LIMIT_W    = 17;
  localparam int unsigned PS_W       = 2;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned GHIST_W    = 64;
  localparam int unsigned VHIST_W    = 32;
  localparam int unsigned CNT_W      = 7;

  localparam int unsigned GRAPHICS_WINDOW = 64;
  localparam int unsigned GRAPHICS_COUNT  = 12;
  localparam int unsigned VIDEO_WINDOW    = 32;
  localparam int unsigned VIDEO_COUNT     = 8;
  localparam int unsigned REGION_SIZE     = 16;
  localparam int unsigned REGIONS_NEEDED  = 3;
  localparam int unsigned NUM_REGIONS     = (GHIST_W + REGION_SIZE - 1) / REGION_SIZE;

  localparam logic [GHIST_W-1:0] GRAPHICS_MASK = (GRAPHICS_WINDOW >= GHIST_W) ? '1 :
      ((GHIST_W'(1) << GRAPHICS_WINDOW) - GHIST_W'(1));
  localparam logic [GHIST_W-1:0] VIDEO_MASK = (VIDEO_WINDOW >= VHIST_W) ?
      {{(GHIST_W-VHIST_W){1'b0}}, {VHIST_W{1'b1}}} :
      ((GHIST_W'(1) << VIDEO_WINDOW) - GHIST_W'(1));
  localparam logic [GHIST_W-1:0] SEGMENT_MASK = (REGION_SIZE >= GHIST_W) ? '1 :
      ((GHIST_W'(1) << REGION_SIZE) - GHIST_W'(1));

  localparam logic [TIME_W-1:0] HIGH_RESIDENCY_MS = TIME_W'(500);
  localparam logic [TIME_W-1:0] IDLE_DELAY_MS     = TIME_W'(10000);
  localparam logic [TIME_W-1:0] LOSS_TIMEOUT_MS   = TIME_W'(3000);

  localparam logic [PS_W-1:0] PS_LOW  = 2'd0;
  localparam logic [PS_W-1:0] PS_MED  = 2'd1;
  localparam logic [PS_W-1:0] PS_HIGH = 2'd2;

  localparam logic MODE_STEP    = 1'b0;
  localparam logic MODE_RESTART = 1'b1;

  localparam logic [STATUS_W-1:0] TSTAT_VALID  = 2'd0;
  localparam logic [STATUS_W-1:0] TSTAT_FAILED = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_TEMP_LIMIT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_HYST    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_PSTATE = 2'd2;

  localparam logic [LIMIT_W-1:0] TEMP_LIMIT_RST   = 17'd95000;
  localparam logic [LIMIT_W-1:0] TEMP_HYST_RST    = 17'd5000;
  localparam logic [PS_W-1:0]    START_PSTATE_RST = PS_LOW;

  typedef struct packed {
    logic [LIMIT_W-1:0] temp_limit;
    logic [LIMIT_W-1:0] temp_hysteresis;
    logic [PS_W-1:0]    start_pstate;
  } cfg_t;

  typedef struct packed {
    logic                     mode;
    logic [TIME_W-1:0]        now_ms;
    logic                     graphics_active;
    logic                     video_active;
    logic [STATUS_W-1:0]      temp_status;
    logic signed [TEMP_W-1:0] temperature;
  } req_t;

  typedef struct packed {
    logic [PS_W-1:0] perf_state;
    logic            thermal_limit_event;
    logic            thermal_recovery_event;
    logic            telemetry_fault_event;
    logic            telemetry_recovery_event;
    logic            graphics_upshift_event;
    logic            video_upshift_event;
    logic            idle_downshift_event;
    logic            config_invalid;
  } rsp_t;

  typedef struct packed {
    logic [GHIST_W-1:0] graphics_bits;
    logic [VHIST_W-1:0] video_bits;
    logic [PS_W-1:0]    target_state;
    logic [TIME_W-1:0]  high_entry_time;
    logic [TIME_W-1:0]  last_active_time;
    logic [TIME_W-1:0]  loss_start_time;
    logic               loss_pending;
    logic               fault_latched;
    logic               limit_engaged;
  } gov_state_t;

  function automatic logic [CNT_W-1:0] popcount(input logic [GHIST_W-1:0] v);
    logic [CNT_W-1:0] n;
    n = '0;
    for (int i = 0; i < GHIST_W; i++) begin
      n = n + CNT_W'(v[i]);
    end
    return n;
  endfunction

  function automatic logic regions_covered(input logic [GHIST_W-1:0] v);
    logic [CNT_W-1:0]   n;
    logic [GHIST_W-1:0] seg;
    n = '0;
    for (int r = 0; r < NUM_REGIONS; r++) begin
      seg = (v >> (r * REGION_SIZE)) & SEGMENT_MASK;
      n = n + CNT_W'(|seg);
    end
    return n >= CNT_W'(REGIONS_NEEDED);
  endfunction

  function automatic logic elapsed(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] since,
                                   input logic [TIME_W-1:0] dur);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return diff >= dur;
  endfunction

endpackage

`default_nettype wire

/* src/gpg_if.sv */
// gpg_if: valid/ready channel interfaces for sample requests, results and
// register writes. Depends on gpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gpg_req_if;
  import gpg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     mode;
  logic [TIME_W-1:0]        now_ms;
  logic                     graphics_active;
  logic                     video_active;
  logic [STATUS_W-1:0]      temp_status;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, mode, now_ms, graphics_active, video_active,
                  temp_status, temperature, input ready);
  modport sink (input valid, mode, now_ms, graphics_active, video_active,
                temp_status, temperature, output ready);
endinterface

interface gpg_rsp_if;
  import gpg_pkg::*;
  logic            valid;
  logic            ready;
  logic [PS_W-1:0] perf_state;
  logic            thermal_limit_event;
  logic            thermal_recovery_event;
  logic            telemetry_fault_event;
  logic            telemetry_recovery_event;
  logic            graphics_upshift_event;
  logic            video_upshift_event;
  logic            idle_downshift_event;
  logic            config_invalid;

  modport source (output valid, perf_state, thermal_limit_event,
                  thermal_recovery_event, telemetry_fault_event,
                  telemetry_recovery_event, graphics_upshift_event,
                  video_upshift_event, idle_downshift_event, config_invalid,
                  input ready);
  modport sink (input valid, perf_state, thermal_limit_event,
                thermal_recovery_event, telemetry_fault_event,
                telemetry_recovery_event, graphics_upshift_event,
                video_upshift_event, idle_downshift_event, config_invalid,
                output ready);
endinterface

interface gpg_cfg_if;
  import gpg_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* src/gpg_cfg.sv */
// gpg_cfg: register file for the temperature limit, hysteresis and start
// state. Depends on gpg_pkg and gpg_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module gpg_cfg (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  gpg_cfg_if.sink           cfg_i,
  output gpg_pkg::cfg_t     cfg_o
);
  import gpg_pkg::*;

  cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.temp_limit      <= TEMP_LIMIT_RST;
      cfg_q.temp_hysteresis <= TEMP_HYST_RST;
      cfg_q.start_pstate    <= START_PSTATE_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_TEMP_LIMIT:   cfg_q.temp_limit      <= cfg_i.data;
        REG_TEMP_HYST:    cfg_q.temp_hysteresis <= cfg_i.data;
        REG_START_PSTATE: cfg_q.start_pstate    <= cfg_i.data[PS_W-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

endmodule

`default_nettype wire

/* src/gpg_step.sv */
// gpg_step: one policy step or restart, from the current governor state, the
// registers and one request to the next state and the result.
// Depends on gpg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gpg_step (
  input  wire gpg_pkg::cfg_t       cfg_i,
  input  wire gpg_pkg::gov_state_t state_i,
  input  wire gpg_pkg::req_t       req_i,
  output gpg_pkg::gov_state_t      state_o,
  output gpg_pkg::rsp_t            rsp_o
);
  import gpg_pkg::*;

  logic signed [TEMP_W:0] temp;
  logic signed [TEMP_W:0] limit;
  logic signed [TEMP_W:0] recover;
  logic                   act;
  logic                   gfx_up;
  logic                   vid_up;
  logic                   cfg_bad;
  gov_state_t             ns;
  rsp_t                   rsp;

  assign temp    = {req_i.temperature[TEMP_W-1], req_i.temperature};
  assign limit   = $signed({2'b00, cfg_i.temp_limit});
  assign recover = limit - $signed({2'b00, cfg_i.temp_hysteresis});
  assign act     = req_i.graphics_active | req_i.video_active;
  assign cfg_bad = (cfg_i.start_pstate > PS_HIGH) || (cfg_i.temp_limit == '0) ||
                   (cfg_i.temp_hysteresis >= cfg_i.temp_limit);

  always_comb begin
    ns     = state_i;
    rsp    = '0;
    gfx_up = 1'b0;
    vid_up = 1'b0;
    if (req_i.mode == MODE_RESTART) begin
      if (cfg_bad) begin
        rsp.config_invalid = 1'b1;
      end else begin
        ns                  = '0;
        ns.target_state     = cfg_i.start_pstate;
        ns.high_entry_time  = req_i.now_ms;
        ns.last_active_time = req_i.now_ms;
        if (temp >= limit) begin
          ns.target_state  = PS_LOW;
          ns.limit_engaged = 1'b1;
        end
      end
    end else begin
      ns.graphics_bits = {state_i.graphics_bits[GHIST_W-2:0], req_i.graphics_active};
      ns.video_bits    = {state_i.video_bits[VHIST_W-2:0], req_i.video_active};
      if (act) begin
        ns.last_active_time = req_i.now_ms;
      end

      if (req_i.temp_status == TSTAT_VALID) begin
        rsp.telemetry_recovery_event = state_i.fault_latched;
        ns.loss_pending  = 1'b0;
        ns.fault_latched = 1'b0;
        if (temp >= limit) begin
          rsp.thermal_limit_event = !state_i.limit_engaged;
          ns.limit_engaged        = 1'b1;
          ns.target_state         = PS_LOW;
        end else if (state_i.limit_engaged && temp < recover) begin
          ns.limit_engaged           = 1'b0;
          rsp.thermal_recovery_event = 1'b1;
        end
      end else begin
        if (req_i.temp_status == TSTAT_FAILED && !state_i.loss_pending) begin
          ns.loss_pending    = 1'b1;
          ns.loss_start_time = req_i.now_ms;
        end
        if (ns.loss_pending && !state_i.fault_latched &&
            elapsed(req_i.now_ms, ns.loss_start_time, LOSS_TIMEOUT_MS)) begin
          ns.fault_latched          = 1'b1;
          ns.target_state           = PS_LOW;
          rsp.telemetry_fault_event = 1'b1;
        end
      end

      // Activity policy only runs while neither thermal override holds
      if (!ns.limit_engaged && !ns.fault_latched) begin
        if (ns.target_state != PS_HIGH) begin
          gfx_up = (popcount(ns.graphics_bits & GRAPHICS_MASK) >= CNT_W'(GRAPHICS_COUNT)) &&
                   regions_covered(ns.graphics_bits);
          vid_up = popcount({{(GHIST_W-VHIST_W){1'b0}}, ns.video_bits} & VIDEO_MASK) >=
                   CNT_W'(VIDEO_COUNT);
          if (gfx_up || vid_up) begin
            ns.high_entry_time         = req_i.now_ms;
            ns.target_state            = PS_HIGH;
            rsp.graphics_upshift_event = gfx_up;
            rsp.video_upshift_event    = vid_up;
          end else if (ns.target_state == PS_MED &&
                       elapsed(req_i.now_ms, ns.last_active_time, IDLE_DELAY_MS)) begin
            ns.target_state          = PS_LOW;
            rsp.idle_downshift_event = 1'b1;
          end
        end else if (!act && elapsed(req_i.now_ms, ns.high_entry_time, HIGH_RESIDENCY_MS) &&
                     elapsed(req_i.now_ms, ns.last_active_time, IDLE_DELAY_MS)) begin
          ns.target_state          = PS_LOW;
          rsp.idle_downshift_event = 1'b1;
        end
      end
    end
    rsp.perf_state = ns.target_state;
  end

  assign state_o = ns;
  assign rsp_o   = rsp;

endmodule

`default_nettype wire

/* src/gpu_pstate_governor.sv */
// Performance-state governor top level: request register, step logic,
// governor state and result register. Depends on gpg_pkg, gpg_if,
// gpg_cfg and gpg_step.
//
// Usage:
//   req_i  carries one policy sample or restart request per handshake.
//   rsp_o  returns exactly one result per request, in request order.
//   cfg_i  writes temp_limit (0), temp_hysteresis (1), start_pstate (2);
//          it is always ready and must be written only while idle.
// Path: an accepted request is held in the request register, then passes
//   the combinational step logic into the result register, which drives
//   rsp_o. Throughput: one request per cycle while rsp_o is not held.
// Stall: while rsp_o is held, the request register still fills; req_i.ready
//   drops only when both the request and result registers hold items.
// Reset: registers return to their defaults, histories and timers clear,
//   and the target state is LOW; no result is pending.
`timescale 1ns / 1ps
`default_nettype none

module gpu_pstate_governor (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gpg_req_if.sink   req_i,
  gpg_rsp_if.source rsp_o,
  gpg_cfg_if.sink   cfg_i
);
  import gpg_pkg::*;

  cfg_t       cfg;
  gov_state_t state_q;
  gov_state_t state_d;
  req_t       req_q;
  logic       req_valid_q;
  rsp_t       rsp_d;
  rsp_t       rsp_q;
  logic       rsp_valid_q;
  logic       advance;

  gpg_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  gpg_step u_step (
    .cfg_i   (cfg),
    .state_i (state_q),
    .req_i   (req_q),
    .state_o (state_d),
    .rsp_o   (rsp_d)
  );

  // Move the held request into the result register when that slot frees
  assign advance     = req_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      req_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.ready && req_i.valid) begin
      req_q.mode            <= req_i.mode;
      req_q.now_ms          <= req_i.now_ms;
      req_q.graphics_active <= req_i.graphics_active;
      req_q.video_active    <= req_i.video_active;
      req_q.temp_status     <= req_i.temp_status;
      req_q.temperature     <= req_i.temperature;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.graphics_bits    <= '0;
      state_q.video_bits       <= '0;
      state_q.target_state     <= START_PSTATE_RST;
      state_q.high_entry_time  <= '0;
      state_q.last_active_time <= '0;
      state_q.loss_start_time  <= '0;
      state_q.loss_pending     <= 1'b0;
      state_q.fault_latched    <= 1'b0;
      state_q.limit_engaged    <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (advance) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid                    = rsp_valid_q;
  assign rsp_o.perf_state               = rsp_q.perf_state;
  assign rsp_o.thermal_limit_event      = rsp_q.thermal_limit_event;
  assign rsp_o.thermal_recovery_event   = rsp_q.thermal_recovery_event;
  assign rsp_o.telemetry_fault_event    = rsp_q.telemetry_fault_event;
  assign rsp_o.telemetry_recovery_event = rsp_q.telemetry_recovery_event;
  assign rsp_o.graphics_upshift_event   = rsp_q.graphics_upshift_event;
  assign rsp_o.video_upshift_event      = rsp_q.video_upshift_event;
  assign rsp_o.idle_downshift_event     = rsp_q.idle_downshift_event;
  assign rsp_o.config_invalid           = rsp_q.config_invalid;

endmodule

`default_nettype wire

/* src/gpg_checker.sv */
// gpg_checker: port-level assertions for the governor, bound to the top
// level. Depends on gpg_pkg and gpu_pstate_governor.
`timescale 1ns / 1ps
`default_nettype none

module gpg_checker (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 rsp_valid_i,
  input wire logic                 rsp_ready_i,
  input wire logic [1:0]           rsp_pstate_i,
  input wire logic                 lim_ev_i,
  input wire logic                 rec_ev_i,
  input wire logic                 flt_ev_i,
  input wire logic                 trec_ev_i,
  input wire logic                 gup_ev_i,
  input wire logic                 vup_ev_i,
  input wire logic                 idle_ev_i,
  input wire logic                 bad_i
);
  import gpg_pkg::*;

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_pstate_i))
    else $error("stalled result changed or dropped");

  a_refused_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && bad_i |-> !(lim_ev_i || rec_ev_i || flt_ev_i || trec_ev_i ||
                               gup_ev_i || vup_ev_i || idle_ev_i))
    else $error("refused restart reported an event");

  a_pstate_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> rsp_pstate_i <= PS_HIGH)
    else $error("illegal performance state");

  a_down_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (lim_ev_i || flt_ev_i || idle_ev_i) |-> rsp_pstate_i == PS_LOW)
    else $error("downshift event without LOW state");

  a_up_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (gup_ev_i || vup_ev_i) |->
      rsp_pstate_i == PS_HIGH && !lim_ev_i && !flt_ev_i)
    else $error("upshift event without HIGH state");

endmodule

bind gpu_pstate_governor gpg_checker u_gpg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_pstate_i (rsp_o.perf_state),
  .lim_ev_i     (rsp_o.thermal_limit_event),
  .rec_ev_i     (rsp_o.thermal_recovery_event),
  .flt_ev_i     (rsp_o.telemetry_fault_event),
  .trec_ev_i    (rsp_o.telemetry_recovery_event),
  .gup_ev_i     (rsp_o.graphics_upshift_event),
  .vup_ev_i     (rsp_o.video_upshift_event),
  .idle_ev_i    (rsp_o.idle_downshift_event),
  .bad_i        (rsp_o.config_invalid)
);

`default_nettype wire

/* bench/gpu_pstate_governor_test.sv */
// gpu_pstate_governor_test: self-checking bench for the performance-state governor.
// Drives sample and restart requests with random gaps and result stalls, predicts each
// result in a local governor copy and checks it. Depends on gpg_pkg, gpg_if and the RTL.
`timescale 1ns / 1ps

module gpu_pstate_governor_test;
  import gpg_pkg::*;

  localparam logic [STATUS_W-1:0] TSTAT_SKIPPED  = 2'd2;
  localparam logic [STATUS_W-1:0] TSTAT_RESERVED = 2'd3;
  localparam logic [PS_W-1:0]     PS_UNDEFINED   = 2'd3;
  localparam int TEMP_MAX    = 131071;
  localparam int TEMP_MIN    = -131072;
  localparam int HOLD_CYCLES = 80;

  logic clk_i;
  logic rst_ni;

  gpg_req_if req ();
  gpg_rsp_if rsp ();
  gpg_cfg_if cfg ();

  gpu_pstate_governor uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp),
    .cfg_i  (cfg)
  );

  // local copy of the governor state and its registers
  logic [GHIST_W-1:0] gfx_hist;
  logic [VHIST_W-1:0] vid_hist;
  logic [PS_W-1:0]    gov_target;
  logic [TIME_W-1:0]  high_since;
  logic [TIME_W-1:0]  last_busy_ms;
  logic [TIME_W-1:0]  loss_since;
  logic               loss_on;
  logic               fault_on;
  logic               limit_on;
  logic [LIMIT_W-1:0] gov_limit;
  logic [LIMIT_W-1:0] gov_hyst;
  logic [PS_W-1:0]    gov_start;

  rsp_t predicted_rsp[$];

  // stimulus state
  logic [TIME_W-1:0] stim_now;
  int unsigned       gfx_pct;
  int unsigned       vid_pct;
  bit                link_down;
  bit                no_gaps;
  int unsigned       hold_req_cnt;
  bit                failed;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned ones_in_window(input logic [GHIST_W-1:0] v,
                                                 input int unsigned w);
    int unsigned n;
    n = 0;
    for (int unsigned i = 0; i < w && i < GHIST_W; i++) n += v[i];
    return n;
  endfunction

  function automatic int unsigned busy_regions(input logic [GHIST_W-1:0] v);
    logic [GHIST_W-1:0] mask;
    int unsigned n;
    int unsigned size;
    size = (REGION_SIZE == 0) ? 1 : REGION_SIZE;
    mask = (size >= GHIST_W) ? '1 : ((64'd1 << size) - 64'd1);
    n = 0;
    for (int unsigned off = 0; off < GHIST_W; off += size)
      if (((v >> off) & mask) != '0) n++;
    return n;
  endfunction

  function automatic bit has_waited(input logic [TIME_W-1:0] now, since, dur);
    logic [TIME_W-1:0] diff;
    diff = now - since;
    return diff >= dur;
  endfunction

  function automatic void reset_governor();
    gov_limit    = TEMP_LIMIT_RST;
    gov_hyst     = TEMP_HYST_RST;
    gov_start    = START_PSTATE_RST;
    gfx_hist     = '0;
    vid_hist     = '0;
    gov_target   = PS_LOW;
    high_since   = '0;
    last_busy_ms = '0;
    loss_since   = '0;
    loss_on      = 1'b0;
    fault_on     = 1'b0;
    limit_on     = 1'b0;
  endfunction

  // advance the governor copy by one request and return its result
  function automatic rsp_t govern_step(input req_t s);
    rsp_t o;
    int   temp_md;
    int   limit_md;
    int   recover_md;
    logic busy;
    logic g_hit;
    logic v_hit;
    o = '0;
    temp_md = $signed(s.temperature);
    limit_md = int'({15'd0, gov_limit});
    recover_md = limit_md - int'({15'd0, gov_hyst});
    if (s.mode == MODE_RESTART) begin
      if (gov_start > PS_HIGH || gov_limit == '0 || gov_hyst >= gov_limit) begin
        o.config_invalid = 1'b1;
      end else begin
        gfx_hist     = '0;
        vid_hist     = '0;
        loss_since   = '0;
        loss_on      = 1'b0;
        fault_on     = 1'b0;
        limit_on     = 1'b0;
        gov_target   = gov_start;
        high_since   = s.now_ms;
        last_busy_ms = s.now_ms;
        if (temp_md >= limit_md) begin
          gov_target = PS_LOW;
          limit_on   = 1'b1;
        end
      end
      o.perf_state = gov_target;
      return o;
    end
    gfx_hist = {gfx_hist[GHIST_W-2:0], s.graphics_active};
    vid_hist = {vid_hist[VHIST_W-2:0], s.video_active};
    busy = s.graphics_active | s.video_active;
    if (busy) last_busy_ms = s.now_ms;
    if (s.temp_status == TSTAT_VALID) begin
      o.telemetry_recovery_event = fault_on;
      loss_on  = 1'b0;
      fault_on = 1'b0;
      if (temp_md >= limit_md) begin
        o.thermal_limit_event = !limit_on;
        limit_on   = 1'b1;
        gov_target = PS_LOW;
      end else if (limit_on && temp_md < recover_md) begin
        limit_on = 1'b0;
        o.thermal_recovery_event = 1'b1;
      end
    end else begin
      if (s.temp_status == TSTAT_FAILED && !loss_on) begin
        loss_on    = 1'b1;
        loss_since = s.now_ms;
      end
      if (loss_on && !fault_on && has_waited(s.now_ms, loss_since, LOSS_TIMEOUT_MS)) begin
        fault_on   = 1'b1;
        gov_target = PS_LOW;
        o.telemetry_fault_event = 1'b1;
      end
    end
    if (!limit_on && !fault_on) begin
      if (gov_target != PS_HIGH) begin
        g_hit = ones_in_window(gfx_hist, GRAPHICS_WINDOW) >= GRAPHICS_COUNT &&
                busy_regions(gfx_hist) >= REGIONS_NEEDED;
        v_hit = ones_in_window({32'd0, vid_hist}, VIDEO_WINDOW) >= VIDEO_COUNT;
        if (g_hit || v_hit) begin
          high_since = s.now_ms;
          gov_target = PS_HIGH;
          o.graphics_upshift_event = g_hit;
          o.video_upshift_event    = v_hit;
        end else if (gov_target == PS_MED &&
                     has_waited(s.now_ms, last_busy_ms, IDLE_DELAY_MS)) begin
          gov_target = PS_LOW;
          o.idle_downshift_event = 1'b1;
        end
      end else if (!busy && has_waited(s.now_ms, high_since, HIGH_RESIDENCY_MS) &&
                   has_waited(s.now_ms, last_busy_ms, IDLE_DELAY_MS)) begin
        gov_target = PS_LOW;
        o.idle_downshift_event = 1'b1;
      end
    end
    o.perf_state = gov_target;
    return o;
  endfunction

  task automatic compare_field(input string name, input logic [1:0] want, got);
    if (got !== want) begin
      failed = 1'b1;
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
    end
  endtask

  task automatic check_result(input rsp_t got);
    rsp_t want;
    if (predicted_rsp.size() == 0) begin
      failed = 1'b1;
      $error("result with no request outstanding");
    end else begin
      want = predicted_rsp.pop_front();
      compare_field("perf_state", want.perf_state, got.perf_state);
      compare_field("thermal_limit_event", want.thermal_limit_event,
                    got.thermal_limit_event);
      compare_field("thermal_recovery_event", want.thermal_recovery_event,
                    got.thermal_recovery_event);
      compare_field("telemetry_fault_event", want.telemetry_fault_event,
                    got.telemetry_fault_event);
      compare_field("telemetry_recovery_event", want.telemetry_recovery_event,
                    got.telemetry_recovery_event);
      compare_field("graphics_upshift_event", want.graphics_upshift_event,
                    got.graphics_upshift_event);
      compare_field("video_upshift_event", want.video_upshift_event,
                    got.video_upshift_event);
      compare_field("idle_downshift_event", want.idle_downshift_event,
                    got.idle_downshift_event);
      compare_field("config_invalid", want.config_invalid, got.config_invalid);
    end
  endtask

  // track register writes, predict each accepted request, check each result
  always @(posedge clk_i) begin : observe
    req_t seen;
    rsp_t got;
    if (rst_ni) begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_TEMP_LIMIT:   gov_limit = cfg.data;
          REG_TEMP_HYST:    gov_hyst  = cfg.data;
          REG_START_PSTATE: gov_start = cfg.data[PS_W-1:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        seen.mode            = req.mode;
        seen.now_ms          = req.now_ms;
        seen.graphics_active = req.graphics_active;
        seen.video_active    = req.video_active;
        seen.temp_status     = req.temp_status;
        seen.temperature     = req.temperature;
        predicted_rsp.push_back(govern_step(seen));
      end
      if (rsp.valid && rsp.ready) begin
        got.perf_state               = rsp.perf_state;
        got.thermal_limit_event      = rsp.thermal_limit_event;
        got.thermal_recovery_event   = rsp.thermal_recovery_event;
        got.telemetry_fault_event    = rsp.telemetry_fault_event;
        got.telemetry_recovery_event = rsp.telemetry_recovery_event;
        got.graphics_upshift_event   = rsp.graphics_upshift_event;
        got.video_upshift_event      = rsp.video_upshift_event;
        got.idle_downshift_event     = rsp.idle_downshift_event;
        got.config_invalid           = rsp.config_invalid;
        check_result(got);
      end
    end
  end

  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_ready_driver
    int stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen = 0;
    rsp.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req_cnt != hold_seen) begin
        hold_seen = hold_req_cnt;
        stall_left = HOLD_CYCLES;
      end else if (stall_left == 0 && !no_gaps && $urandom_range(0, 5) == 0) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // offer one request; valid stays high afterwards unless a gap follows
  task automatic send_sample(input req_t item);
    int gap;
    gap = (no_gaps || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid           <= 1'b1;
    req.mode            <= item.mode;
    req.now_ms          <= item.now_ms;
    req.graphics_active <= item.graphics_active;
    req.video_active    <= item.video_active;
    req.temp_status     <= item.temp_status;
    req.temperature     <= item.temperature;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
  endtask

  function automatic req_t make_sample(input logic mode, input logic [TIME_W-1:0] now,
                                       input logic g, v, input logic [STATUS_W-1:0] st,
                                       input int temp);
    req_t s;
    s.mode            = mode;
    s.now_ms          = now;
    s.graphics_active = g;
    s.video_active    = v;
    s.temp_status     = st;
    s.temperature     = TEMP_W'(temp);
    return s;
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(0, 5))
      0, 1:    return 0;
      2:       return 5;
      3:       return 15;
      4:       return 35;
      default: return 100;
    endcase
  endfunction

  // well-formed sample stream around the current limits, with some noise
  function automatic req_t next_sample();
    req_t s;
    int unsigned r;
    int t;
    int lim;
    int hy;
    r = $urandom_range(0, 99);
    if (r < 78) stim_now += $urandom_range(1, 50);
    else if (r < 92) stim_now += $urandom_range(100, 800);
    else if (r < 99) stim_now += $urandom_range(2000, 12000);
    else if ($urandom_range(0, 1) == 0) stim_now = {$urandom, $urandom};
    else stim_now = '1 - $urandom_range(0, 5000);
    if ($urandom_range(0, 39) == 0) gfx_pct = pick_pct();
    if ($urandom_range(0, 39) == 0) vid_pct = pick_pct();
    if ($urandom_range(0, 49) == 0) link_down = !link_down;
    s.mode            = ($urandom_range(0, 39) == 0) ? MODE_RESTART : MODE_STEP;
    s.now_ms          = stim_now;
    s.graphics_active = $urandom_range(0, 99) < gfx_pct;
    s.video_active    = $urandom_range(0, 99) < vid_pct;
    r = $urandom_range(0, 99);
    if (link_down)
      s.temp_status = (r < 70) ? TSTAT_FAILED : (r < 85) ? TSTAT_SKIPPED : TSTAT_RESERVED;
    else
      s.temp_status = (r < 85) ? TSTAT_VALID : (r < 95) ? TSTAT_SKIPPED : TSTAT_RESERVED;
    lim = int'({15'd0, gov_limit});
    hy  = int'({15'd0, gov_hyst});
    r = $urandom_range(0, 99);
    if (r < 60) t = lim - hy - int'($urandom_range(1, 20000));
    else if (r < 75) t = lim - int'($urandom_range(0, hy));
    else if (r < 92) t = lim + int'($urandom_range(0, 3000));
    else t = $signed(TEMP_W'($urandom));
    if (t > TEMP_MAX) t = TEMP_MAX;
    if (t < TEMP_MIN) t = TEMP_MIN;
    s.temperature = TEMP_W'(t);
    return s;
  endfunction

  task automatic run_random(input int n);
    no_gaps <= ($urandom_range(0, 3) == 0);
    repeat (n) send_sample(next_sample());
  endtask

  task automatic restart_at(input int temp);
    stim_now += 100;
    send_sample(make_sample(MODE_RESTART, stim_now, 1'b0, 1'b0, TSTAT_VALID, temp));
  endtask

  // drop valid, wait for every outstanding result, then let the pipeline settle
  task automatic drain_pipeline();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (predicted_rsp.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
  endtask

  task automatic apply_settings(input logic [LIMIT_W-1:0] limit, hyst,
                                input logic [PS_W-1:0] start);
    drain_pipeline();
    cfg_write(REG_TEMP_LIMIT, limit);
    cfg_write(REG_TEMP_HYST, hyst);
    cfg_write(REG_START_PSTATE, CFG_DATA_W'(start));
    cfg.valid <= 1'b0;
  endtask

  task automatic test_directed();
    logic [TIME_W-1:0] t;
    send_sample(make_sample(MODE_RESTART, 64'd1000, 1'b1, 1'b1, TSTAT_FAILED, 20000));
    send_sample(make_sample(MODE_STEP, 64'd1010, 1'b0, 1'b0, TSTAT_VALID, TEMP_MAX));
    send_sample(make_sample(MODE_STEP, 64'd1020, 1'b0, 1'b0, TSTAT_VALID, TEMP_MIN));
    send_sample(make_sample(MODE_STEP, 64'd1030, 1'b0, 1'b0, TSTAT_RESERVED, TEMP_MAX));
    send_sample(make_sample(MODE_STEP, 64'd1040, 1'b0, 1'b0, TSTAT_SKIPPED, TEMP_MAX));
    // telemetry loss: fault exactly at the timeout, then a valid read clears it
    send_sample(make_sample(MODE_STEP, 64'd2000, 1'b0, 1'b0, TSTAT_FAILED, 0));
    send_sample(make_sample(MODE_STEP, 64'd4999, 1'b0, 1'b0, TSTAT_FAILED, 0));
    send_sample(make_sample(MODE_STEP, 64'd5000, 1'b0, 1'b0, TSTAT_SKIPPED, 0));
    send_sample(make_sample(MODE_STEP, 64'd5001, 1'b0, 1'b0, TSTAT_VALID, 30000));
    t = 64'd5001;
    repeat (8) begin
      t += 10;
      send_sample(make_sample(MODE_STEP, t, 1'b1, 1'b1, TSTAT_VALID, 30000));
    end
    t += 10001;
    send_sample(make_sample(MODE_STEP, t, 1'b0, 1'b0, TSTAT_VALID, 30000));
    // time wraps past the top of the counter
    send_sample(make_sample(MODE_STEP, '1, 1'b1, 1'b0, TSTAT_VALID, 0));
    send_sample(make_sample(MODE_STEP, 64'd5, 1'b0, 1'b0, TSTAT_VALID, 0));
    send_sample(make_sample(MODE_RESTART, 64'd0, 1'b0, 1'b0, TSTAT_VALID, TEMP_MAX));
    send_sample(make_sample(MODE_STEP, 64'd20, 1'b0, 1'b1, TSTAT_VALID, TEMP_MAX));
    stim_now = 64'd100;
  endtask

  task automatic test_thermal_extremes();
    apply_settings(17'd1, 17'd0, PS_HIGH);
    restart_at(25000);
    run_random(120);
    apply_settings(17'd131071, 17'd0, PS_LOW);
    restart_at(25000);
    run_random(100);
  endtask

  task automatic test_invalid_settings();
    apply_settings(17'd131071, 17'd131071, PS_LOW);
    restart_at(25000);
    run_random(40);
    apply_settings(17'd0, 17'd0, PS_MED);
    restart_at(25000);
    run_random(30);
    apply_settings(17'd60000, 17'd5000, PS_UNDEFINED);
    restart_at(25000);
    run_random(30);
  endtask

  task automatic test_live_limit();
    apply_settings(17'd1000, 17'd0, PS_MED);
    restart_at(500);
    run_random(60);
    // no restart: the new limit applies live and the recovery point goes negative
    apply_settings(17'd100, 17'd5000, PS_HIGH);
    run_random(100);
  endtask

  task automatic test_medium_idle();
    apply_settings(TEMP_LIMIT_RST, TEMP_HYST_RST, PS_MED);
    restart_at(25000);
    stim_now += 10000;
    send_sample(make_sample(MODE_STEP, stim_now, 1'b0, 1'b0, TSTAT_VALID, 25000));
    run_random(100);
  endtask

  task automatic test_backpressure();
    drain_pipeline();
    no_gaps <= 1'b1;
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (60) send_sample(next_sample());
    no_gaps <= 1'b0;
  endtask

  task automatic test_random_soak();
    apply_settings(TEMP_LIMIT_RST, TEMP_HYST_RST, START_PSTATE_RST);
    restart_at(25000);
    run_random(400);
  endtask

  initial begin
    reset_governor();
    predicted_rsp.delete();
    stim_now     = '0;
    gfx_pct      = 15;
    vid_pct      = 5;
    link_down    = 1'b0;
    no_gaps      = 1'b0;
    hold_req_cnt = 0;
    failed       = 1'b0;
    rst_ni              <= 1'b0;
    req.valid           <= 1'b0;
    req.mode            <= MODE_STEP;
    req.now_ms          <= '0;
    req.graphics_active <= 1'b0;
    req.video_active    <= 1'b0;
    req.temp_status     <= TSTAT_VALID;
    req.temperature     <= '0;
    cfg.valid           <= 1'b0;
    cfg.index           <= REG_TEMP_LIMIT;
    cfg.data            <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_thermal_extremes();
    test_invalid_settings();
    test_live_limit();
    test_medium_idle();
    test_backpressure();
    test_random_soak();
    drain_pipeline();
    repeat (8) @(posedge clk_i);

    if (predicted_rsp.size() != 0) begin
      failed = 1'b1;
      $error("%0d results never arrived", predicted_rsp.size());
    end
    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule

/* gpu_pstate_governor.f */
src/gpg_pkg.sv
src/gpg_if.sv
src/gpg_cfg.sv
src/gpg_step.sv
src/gpu_pstate_governor.sv
src/gpg_checker.sv
bench/gpu_pstate_governor_test.sv
